@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers. They compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

@@ src/fr90bg_pkg.sv @@
// ----------------------------------------------------------------------------
// fr90bg_pkg
// Frame geometry, widths and codes shared by the rotated frame store.
// ----------------------------------------------------------------------------
package fr90bg_pkg;

    localparam int LOGICAL_WIDTH  = 296;
    localparam int LOGICAL_HEIGHT = 128;

    localparam int LOG_BPR   = (LOGICAL_WIDTH + 7) / 8;
    localparam int LOG_BYTES = LOG_BPR * LOGICAL_HEIGHT;
    localparam int NAT_BPR   = LOGICAL_HEIGHT / 8;
    localparam int NAT_BYTES = NAT_BPR * LOGICAL_WIDTH;

    localparam int IDX_W  = 13;
    localparam int DATA_W = 8;
    localparam int ADDR_W = $clog2(LOG_BYTES);
    localparam int COL_W  = $clog2(NAT_BPR);
    localparam int ROW_W  = IDX_W - COL_W;
    localparam int CNT_W  = 3;

    localparam logic [ADDR_W-1:0] BPR_STEP    = ADDR_W'(LOG_BPR);
    localparam logic [ADDR_W-1:0] PY_MAX      = ADDR_W'(LOGICAL_HEIGHT - 1);
    localparam logic [ROW_W-1:0]  PX_MAX      = ROW_W'(LOGICAL_WIDTH - 1);
    localparam logic [IDX_W-1:0]  LOG_LIMIT   = IDX_W'(LOG_BYTES);
    localparam logic [IDX_W-1:0]  NAT_LIMIT   = IDX_W'(NAT_BYTES);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic ROT_CW  = 1'b0;
    localparam logic ROT_CCW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST
    } state_t;

endpackage

@@ src/fr90bg_ram.sv @@
// ----------------------------------------------------------------------------
// fr90bg_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fr90bg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/frame_rotate_90_byte_gather_top.sv @@
// ----------------------------------------------------------------------------
// frame_rotate_90_byte_gather_top
// 1bpp frame store with 90-degree rotated native byte readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per beat:
//   opcode 0 stores write_data at logical_index, opcode 1 reads the native
//   (rotated) byte at native_index. Every command yields exactly one beat on
//   the output channel (out_valid / out_stall) with pixel_byte and in_range.
//   cfg_we / cfg_wdata set the rotation: 0 clockwise, 1 counter-clockwise.
//   Writes and out-of-range reads: result is registered on the accept edge,
//   and the input stays open for the next command unless the receiver stalls.
//   In-range reads: eight frame bytes are fetched through the single RAM read
//   port, one per cycle, and one pixel bit is shifted into the result per
//   cycle. ST_READ issues the eight byte reads and ST_LAST registers the
//   result; the input is held off until the gather is done.
//   Commands are taken only while the output register is empty or being
//   drained in the same cycle; a stalled receiver holds the result and
//   stalls the input in turn.
//   Reset clears the control state and rotation; frame contents are not
//   cleared and must be written before they are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_rotate_90_byte_gather_top
    import fr90bg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [IDX_W-1:0]  logical_index,
    input  logic [DATA_W-1:0] write_data,
    input  logic [IDX_W-1:0]  native_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] pixel_byte,
    output logic              in_range
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [2:0]          bitsel_reg, bitsel_next;
    logic                rd_pend_reg;
    logic [DATA_W-2:0]   shift_reg, shift_next;
    logic [DATA_W-1:0]   pixel_reg, pixel_next;
    logic                range_reg, range_next;
    logic                out_valid_reg, out_valid_next;
    logic                rotation_reg;

    logic                accept;
    logic                ram_we;
    logic [DATA_W-1:0]   ram_rdata;
    logic                pix_bit;

    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [ROW_W-1:0]    px_ccw;
    logic [ADDR_W-1:0]   nx0;
    logic [ADDR_W-1:0]   py_cw;
    logic [ADDR_W-1:0]   line_sel;
    logic [ADDR_W-1:0]   start_addr;
    logic [2:0]          start_bit;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign ram_we   = accept && (opcode == OP_WRITE) && (logical_index < LOG_LIMIT);

    fr90bg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LOG_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (logical_index[ADDR_W-1:0]),
        .wdata (write_data),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // MSB-first pixels: pixel x&7 lives at byte bit 7-(x&7)
    assign pix_bit = ram_rdata[~bitsel_reg];

    // First logical byte of the native byte's 8-pixel run
    assign col        = native_index[COL_W-1:0];
    assign row        = native_index[IDX_W-1:COL_W];
    assign px_ccw     = PX_MAX - row;
    assign nx0        = ADDR_W'({col, 3'b000});
    assign py_cw      = PY_MAX - nx0;
    assign line_sel   = (rotation_reg == ROT_CCW) ? nx0 : py_cw;
    assign start_addr = ADDR_W'(line_sel * BPR_STEP)
                      + ((rotation_reg == ROT_CCW) ? ADDR_W'(px_ccw[ROW_W-1:3])
                                                  : ADDR_W'(row[ROW_W-1:3]));
    assign start_bit  = (rotation_reg == ROT_CCW) ? px_ccw[2:0] : row[2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            rotation_reg  <= ROT_CW;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= (state_reg == ST_READ);
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                rotation_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        bitsel_reg <= bitsel_next;
        shift_reg  <= shift_next;
        pixel_reg  <= pixel_next;
        range_reg  <= range_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        bitsel_next    = bitsel_reg;
        shift_next     = shift_reg;
        pixel_next     = pixel_reg;
        range_next     = range_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (rd_pend_reg)
        begin
            shift_next = {shift_reg[DATA_W-3:0], pix_bit};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_WRITE)
                    begin
                        out_valid_next = 1'b1;
                        pixel_next     = '0;
                        range_next     = 1'b1;
                    end
                    else if (native_index >= NAT_LIMIT)
                    begin
                        out_valid_next = 1'b1;
                        pixel_next     = '0;
                        range_next     = 1'b0;
                    end
                    else
                    begin
                        state_next  = ST_READ;
                        cnt_next    = '0;
                        addr_next   = start_addr;
                        bitsel_next = start_bit;
                    end
                end
            end
            ST_READ:
            begin
                // step back (cw) or forward (ccw) one logical row per native bit
                addr_next = (rotation_reg == ROT_CCW) ? addr_reg + BPR_STEP
                                                      : addr_reg - BPR_STEP;
                cnt_next  = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                out_valid_next = 1'b1;
                pixel_next     = {shift_reg, pix_bit};
                range_next     = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_reg;
    assign in_range   = range_reg;

    `ASSERT_NEVER(a_no_write_in_gather, ram_we && (state_reg != ST_IDLE), "frame write during gather")
    `ASSERT_NEVER(a_out_free_at_last, (state_reg == ST_LAST) && out_valid_reg, "result register busy at gather end")
    `ASSERT_PROP(a_last_gives_result, (state_reg == ST_LAST) |=> (out_valid_reg && range_reg), "gather result not presented")
    `ASSERT_PROP(a_range_zero_byte, (out_valid_reg && !range_reg) |-> (pixel_reg == '0), "out-of-range beat carries pixels")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotated 1bpp frame store. Commands are queued
// per phase (one rotation per phase), driven with random gaps, and every
// result beat is compared against a local model of the frame and rotation.
// ----------------------------------------------------------------------------
module tb;
    import fr90bg_pkg::*;

    localparam int PHASE_ITEMS = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct {
        logic              op;
        logic [IDX_W-1:0]  lidx;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  nidx;
        int                gap;
    } fb_cmd_t;

    typedef struct {
        logic [DATA_W-1:0] pixel;
        logic              hit;
    } fb_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              opcode = OP_WRITE;
    logic [IDX_W-1:0]  logical_index = '0;
    logic [DATA_W-1:0] write_data = '0;
    logic [IDX_W-1:0]  native_index = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] pixel_byte;
    logic              in_range;

    frame_rotate_90_byte_gather_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .logical_index (logical_index),
        .write_data    (write_data),
        .native_index  (native_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_byte    (pixel_byte),
        .in_range      (in_range)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // command stream and expected result beats
    fb_cmd_t    cmd_fifo[$];
    fb_result_t expected_beats[$];
    fb_cmd_t    cur_cmd;
    int         send_gap = 0;

    // frame model seen by the checker
    logic [DATA_W-1:0] frame_mem [LOG_BYTES];
    logic              rot_cfg = ROT_CW;

    // generator bookkeeping
    bit   written [LOG_BYTES];
    logic plan_rot = ROT_CW;
    int   items_queued = 0;
    int   tx_calm = 0;
    int   hot_base = 0;

    // receiver side
    int results_checked = 0;
    int fail_count = 0;
    int rx_wait = 0;
    int rx_calm = 0;
    int long_hold_left = 0;
    bit long_hold_done = 1'b0;
    int cycle_count = 0;

    // logical byte address and bit position feeding one native bit
    function automatic void pixel_loc(input logic rot, input int nidx, input int b,
                                      output int addr, output int bitpos);
        int row, nx, px, py;
        row = nidx / NAT_BPR;
        nx  = (nidx % NAT_BPR) * 8 + b;
        if (rot == ROT_CW)
        begin
            px = row;
            py = LOGICAL_HEIGHT - 1 - nx;
        end
        else
        begin
            px = LOGICAL_WIDTH - 1 - row;
            py = nx;
        end
        addr   = py * LOG_BPR + px / 8;
        bitpos = 7 - (px % 8);
    endfunction

    function fb_result_t predict_frame_result(input fb_cmd_t c);
        fb_result_t r;
        int addr, bitpos;
        r.pixel = '0;
        r.hit   = 1'b1;
        if (c.op == OP_WRITE)
        begin
            if (c.lidx < LOG_LIMIT)
                frame_mem[c.lidx] = c.wdata;
        end
        else if (c.nidx >= NAT_LIMIT)
            r.hit = 1'b0;
        else
        begin
            r.pixel = 8'hFF;
            for (int b = 0; b < 8; b++)
            begin
                pixel_loc(rot_cfg, int'(c.nidx), b, addr, bitpos);
                if (frame_mem[addr][bitpos] == 1'b0)
                    r.pixel[7-b] = 1'b0;
            end
        end
        return r;
    endfunction

    function int send_pause();
        if (tx_calm != 0)
        begin
            tx_calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
        begin
            tx_calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function int recv_pause();
        if (rx_calm != 0)
        begin
            rx_calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
        begin
            rx_calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function void push_write(input int lidx, input int data);
        fb_cmd_t c;
        c.op    = OP_WRITE;
        c.lidx  = IDX_W'(lidx);
        c.wdata = DATA_W'(data);
        c.nidx  = IDX_W'($urandom);
        c.gap   = send_pause();
        if (lidx < LOG_BYTES)
            written[lidx] = 1'b1;
        cmd_fifo.push_back(c);
        items_queued++;
    endfunction

    function void push_read(input int nidx);
        fb_cmd_t c;
        c.op    = OP_READ;
        c.lidx  = IDX_W'($urandom);
        c.wdata = DATA_W'($urandom);
        c.nidx  = IDX_W'(nidx);
        c.gap   = send_pause();
        cmd_fifo.push_back(c);
        items_queued++;
    endfunction

    // read a native byte, writing any source byte not yet written first
    // (fill < 0 picks random contents)
    function void queue_read(input int nidx, input int fill);
        int addr, bitpos;
        for (int b = 0; b < 8; b++)
        begin
            pixel_loc(plan_rot, nidx, b, addr, bitpos);
            if (!written[addr])
                push_write(addr, (fill < 0) ? int'($urandom_range(0, 255)) : fill);
        end
        push_read(nidx);
    endfunction

    function void random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            queue_read(hot_base + $urandom_range(0, 255), -1);
        else if (pick < 55)
            queue_read($urandom_range(0, NAT_BYTES - 1), -1);
        else if (pick < 80)
            push_write($urandom_range(0, LOG_BYTES - 1), $urandom_range(0, 255));
        else if (pick < 90)
            push_write($urandom_range(LOG_BYTES, 8191), $urandom_range(0, 255));
        else
            push_read($urandom_range(NAT_BYTES, 8191));
    endfunction

    // driver: a beat is accepted when in_valid is high and in_stall is low
    always @(posedge clk)
    begin
        fb_cmd_t c;
        if (rst_n && !(in_valid && in_stall))
        begin
            if (in_valid)
                expected_beats.push_back(predict_frame_result(cur_cmd));
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (cmd_fifo.size() != 0)
            begin
                c = cmd_fifo.pop_front();
                cur_cmd       <= c;
                opcode        <= c.op;
                logical_index <= c.lidx;
                write_data    <= c.wdata;
                native_index  <= c.nidx;
                in_valid      <= 1'b1;
                send_gap      <= c.gap;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    always @(posedge clk)
    begin
        fb_result_t want;
        int nw;
        if (rst_n)
        begin
            nw = rx_wait;
            if (out_valid && !out_stall)
            begin
                results_checked <= results_checked + 1;
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: pixel_byte %0h in_range %0b",
                           pixel_byte, in_range);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (pixel_byte !== want.pixel)
                    begin
                        $error("pixel_byte mismatch: expected %02h, actual %02h",
                               want.pixel, pixel_byte);
                        fail_count++;
                    end
                    if (in_range !== want.hit)
                    begin
                        $error("in_range mismatch: expected %0b, actual %0b",
                               want.hit, in_range);
                        fail_count++;
                    end
                end
                nw = recv_pause();
            end
            else if (nw != 0)
                nw--;
            rx_wait   <= nw;
            out_stall <= (nw != 0) || (long_hold_left != 0);
        end
    end

    // one long receiver hold-off so the block backs up and stalls its input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_left != 0)
                long_hold_left <= long_hold_left - 1;
            else if (!long_hold_done && results_checked >= 150)
            begin
                long_hold_left <= 300;
                long_hold_done <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_rotation(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        rot_cfg = v;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (results_checked < items_queued)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        int phase_end;
        logic rot;
        foreach (frame_mem[i])
            frame_mem[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            rot = (ph % 2 == 1) ? ROT_CCW : ROT_CW;
            set_rotation(rot);
            plan_rot = rot;
            hot_base = $urandom_range(0, NAT_BYTES - 256);
            if (ph == 0)
            begin
                // frame corners, dropped writes past the frame,
                // all-black and all-white gathers, reads past the frame
                push_write(0, 8'h00);
                push_write(LOG_BYTES - 1, 8'hFF);
                push_write(LOG_BYTES, 8'hA5);
                push_write(8191, 8'h5A);
                queue_read(0, 8'h00);
                queue_read(NAT_BYTES - 1, 8'hFF);
                push_read(NAT_BYTES);
                push_read(8191);
            end
            else
            begin
                queue_read(0, -1);
                queue_read(NAT_BYTES - 1, -1);
            end
            phase_end = items_queued + PHASE_ITEMS;
            while (items_queued < phase_end)
                random_item();
            wait_drained();
        end
        if (expected_beats.size() != 0)
        begin
            $error("%0d expected result beats never arrived", expected_beats.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
